// ----- rtl/core/lkvt_pkg.sv -----
// Shared types and constants of the linear key/value table.
// No dependencies; every other file of the block imports this package.
package lkvt_pkg;

  localparam int CAPACITY_DEF  = 512;
  localparam int KEY_W         = 32;
  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 10;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

endpackage

// ----- rtl/core/linear_key_value_table.sv -----
// Top level of the linear key/value table: command sequencer and count.
// Depends on lkvt_pkg and lkvt_store.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  command  | start_i / busy_o     | func_i, key_i, write_value_i
//  result   | done_o (one cycle)   | read_value_o, found_o, status_o, entry_count_o
//
// A command is taken when start_i is high and busy_o is low. Clear finishes in
// the cycle after it is taken. Read and write scan the stored pairs through the
// store's single read port, one pair per cycle. A delete scans up to the hit
// and then moves each later pair down one slot, again one pair per cycle
// through the same port. Reset clears the pair count and the control state,
// not the stores; the stores need no clearing pass. The receiver cannot stall:
// each result is shown for one cycle only.
module linear_key_value_table #(
  parameter int CAPACITY = lkvt_pkg::CAPACITY_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       start_i,
  output logic                                       busy_o,
  input  logic        [1:0]                          func_i,
  input  logic signed [lkvt_pkg::KEY_W-1:0]          key_i,
  input  logic signed [lkvt_pkg::VALUE_W-1:0]        write_value_i,
  output logic                                       done_o,
  output logic signed [lkvt_pkg::VALUE_W-1:0]        read_value_o,
  output logic                                       found_o,
  output logic                                       status_o,
  output logic        [lkvt_pkg::ENTRY_COUNT_W-1:0]  entry_count_o
);
  import lkvt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0]               state_q, state_d;
  func_e                    func_q;
  logic signed [KEY_W-1:0]  key_q;
  logic signed [VALUE_W-1:0] wval_q;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            pend_idx_q, pend_idx_d;
  logic                     pend_q, pend_d;

  logic                     done_q, done_d;
  logic signed [VALUE_W-1:0] rv_q, rv_d;
  logic                     found_q, found_d;
  logic                     status_q, status_d;
  logic [ENTRY_COUNT_W-1:0] ecount_q;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic signed [KEY_W-1:0]  wkey;
  logic signed [VALUE_W-1:0] wval;
  logic signed [KEY_W-1:0]  rd_key;
  logic signed [VALUE_W-1:0] rd_val;
  logic [CW-1:0]            shift_addr;
  logic                     issue;
  logic                     hit;
  logic                     accept;

  lkvt_store #(.CAPACITY(CAPACITY)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wkey_i  (wkey),
    .wval_i  (wval),
    .raddr_i (idx_q[AW-1:0]),
    .rkey_o  (rd_key),
    .rval_o  (rd_val)
  );

  assign accept     = start_i && (state_q == ST_IDLE);
  assign issue      = (idx_q < count_q);
  // Read data in this cycle belongs to the slot issued in the previous cycle.
  assign hit        = pend_q && (rd_key == key_q);
  assign shift_addr = pend_idx_q - CW'(1);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    pend_idx_d = pend_idx_q;
    pend_d     = 1'b0;
    done_d     = 1'b0;
    rv_d       = rv_q;
    found_d    = found_q;
    status_d   = status_q;
    we         = 1'b0;
    waddr      = pend_idx_q[AW-1:0];
    wkey       = key_q;
    wval       = wval_q;

    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          if (func_e'(func_i) == FUNC_CLEAR) begin
            count_d  = '0;
            done_d   = 1'b1;
            rv_d     = '0;
            found_d  = 1'b0;
            status_d = 1'b0;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_d     = issue;
        pend_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (hit) begin
          found_d  = 1'b1;
          status_d = 1'b0;
          rv_d     = '0;
          case (func_q)
            FUNC_READ: begin
              rv_d    = rd_val;
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
            FUNC_WRITE: begin
              we      = 1'b1;
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end
            default: begin
              // Delete: move every later pair down starting after the hit.
              pend_d  = 1'b0;
              idx_d   = pend_idx_q + CW'(1);
              state_d = ST_SHIFT;
            end
          endcase
        end else if (!issue) begin
          found_d  = 1'b0;
          status_d = 1'b0;
          rv_d     = '0;
          done_d   = 1'b1;
          state_d  = ST_IDLE;
          if (func_q == FUNC_WRITE) begin
            if (count_q == CAP_CNT) begin
              status_d = 1'b1;
            end else begin
              we      = 1'b1;
              waddr   = count_q[AW-1:0];
              count_d = count_q + CW'(1);
            end
          end
        end
      end
      ST_SHIFT: begin
        pend_d     = issue;
        pend_idx_d = idx_q;
        if (issue) begin
          idx_d = idx_q + CW'(1);
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = shift_addr[AW-1:0];
          wkey  = rd_key;
          wval  = rd_val;
        end
        if (!issue && !pend_q) begin
          count_d = count_q - CW'(1);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      ecount_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (done_d) begin
        ecount_q <= ENTRY_COUNT_W'(count_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    rv_q       <= rv_d;
    found_q    <= found_d;
    status_q   <= status_d;
    if (accept) begin
      func_q <= func_e'(func_i);
      key_q  <= key_i;
      wval_q <= write_value_i;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign read_value_o  = rv_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = ecount_q;

endmodule

// ----- rtl/core/lkvt_store.sv -----
// Key and value storage of the table: one write port and one read port,
// read data registered. Depends on lkvt_pkg.
module lkvt_store #(
  parameter int CAPACITY = lkvt_pkg::CAPACITY_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic        [$clog2(CAPACITY)-1:0]   waddr_i,
  input  logic signed [lkvt_pkg::KEY_W-1:0]    wkey_i,
  input  logic signed [lkvt_pkg::VALUE_W-1:0]  wval_i,
  input  logic        [$clog2(CAPACITY)-1:0]   raddr_i,
  output logic signed [lkvt_pkg::KEY_W-1:0]    rkey_o,
  output logic signed [lkvt_pkg::VALUE_W-1:0]  rval_o
);
  import lkvt_pkg::*;

  logic signed [KEY_W-1:0]   key_mem [CAPACITY];
  logic signed [VALUE_W-1:0] val_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end

endmodule

// ----- rtl/core/lkvt_check.sv -----
// Port-level checks of the linear key/value table, bound to the top level.
// Depends on lkvt_pkg and linear_key_value_table.
module lkvt_check (
  input logic                                       clk_i,
  input logic                                       rst_ni,
  input logic                                       start_i,
  input logic                                       busy_o,
  input logic        [1:0]                          func_i,
  input logic                                       done_o,
  input logic signed [lkvt_pkg::VALUE_W-1:0]        read_value_o,
  input logic                                       found_o,
  input logic                                       status_o
);
  import lkvt_pkg::*;

  // A clear finishes in the cycle after it is taken and leaves the block ready.
  a_clear_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i == FUNC_CLEAR) |=> (done_o && !busy_o))
    else $error("clear did not finish in one cycle");

  // Any other command keeps the block busy while it scans.
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && func_i != FUNC_CLEAR) |=> (busy_o && !done_o))
    else $error("scanning command did not raise busy");

  // The end of a busy period is always marked by a result.
  a_busy_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // A full-table refusal is a miss with no data, and misses carry zero data.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o || !found_o)) |-> (!found_o && read_value_o == '0))
    else $error("miss or full result carries data");

endmodule

bind linear_key_value_table lkvt_check u_check (.*);
